// ===== hw/rtl/tce_pkg.sv =====
// shared types, codes and constants of the text console engine
package tce_pkg;

  localparam int DEF_COLUMNS     = 80;
  localparam int DEF_ROWS        = 25;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam logic [2:0] OP_PUT_CURSOR = 3'd0;
  localparam logic [2:0] OP_PUT_CELL   = 3'd1;
  localparam logic [2:0] OP_SET_CURSOR = 3'd2;
  localparam logic [2:0] OP_CLEAR      = 3'd3;
  localparam logic [2:0] OP_READ_CELL  = 3'd4;

  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h07;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] character;
    logic [6:0] column;
    logic [4:0] row;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_linear;
    logic [7:0]  cell_character;
    logic [7:0]  cell_color;
    logic        scrolled;
  } out_word_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_PUT_CURSOR,
    CMD_PUT_CELL,
    CMD_SET_CURSOR,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] character;
    logic [6:0] column;
    logic [4:0] row;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

// ===== hw/rtl/tce_front.sv =====
// front end: takes input words, checks bounds and turns them into commands
module tce_front import tce_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic         in_valid,
  output logic         in_stall,
  input  in_word_t     in_word,
  input  logic         q_full,
  input  back_status_t status,
  output logic         push,
  output cmd_t         cmd
);

  logic in_range;

  assign in_stall = q_full || status.init_busy;
  assign push     = in_valid && !in_stall;
  assign in_range = (int'(in_word.column) < COLUMNS) && (int'(in_word.row) < ROWS);

  always_comb begin
    cmd.character = in_word.character;
    cmd.column    = in_word.column;
    cmd.row       = in_word.row;
    case (in_word.op)
      OP_PUT_CURSOR: cmd.kind = CMD_PUT_CURSOR;
      OP_PUT_CELL:   cmd.kind = in_range ? CMD_PUT_CELL : CMD_NOP;
      OP_SET_CURSOR: cmd.kind = in_range ? CMD_SET_CURSOR : CMD_NOP;
      OP_CLEAR:      cmd.kind = CMD_CLEAR;
      OP_READ_CELL:  cmd.kind = in_range ? CMD_READ : CMD_NOP;
      default:       cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== hw/rtl/tce_queue.sv =====
// short command queue between front and back end
module tce_queue import tce_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/tce_back.sv =====
// back end: screen memory, cursor, scroll and clear sequencer, result register
module tce_back import tce_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [7:0]   cfg_data,
  input  cmd_t         head,
  input  logic         q_empty,
  output logic         pop,
  output back_status_t status,
  output logic         out_valid,
  input  logic         out_stall,
  output out_word_t    out_word
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int COPY_N = CELLS - COLUMNS;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_COPY  = 6'b001000,
    S_FILL  = 6'b010000,
    S_CLEAR = 6'b100000
  } state_t;

  function automatic logic [CELL_W-1:0] lin(input logic [6:0] c, input logic [4:0] r);
    return CELL_W'(r) * CELL_W'(COLUMNS) + CELL_W'(c);
  endfunction

  logic [15:0]       mem [CELLS];
  logic [15:0]       rdata;
  logic              wen;
  logic [CELL_W-1:0] waddr;
  logic [15:0]       wdata;
  logic              ren;
  logic [CELL_W-1:0] raddr;

  state_t            state;
  state_t            state_next;
  logic [CELL_W-1:0] cnt;
  logic [CELL_W-1:0] cnt_next;
  logic [6:0]        cc;
  logic [6:0]        cc_next;
  logic [4:0]        cl;
  logic [4:0]        cl_next;
  logic [7:0]        text_color;
  logic              out_free;
  logic              load;
  logic              last_row;
  logic              go_scroll;
  out_word_t         res;

  assign out_free         = !out_valid || !out_stall;
  assign status.init_busy = (state == S_INIT);
  assign last_row         = (cl == 5'(ROWS - 1));

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    wen        = 1'b0;
    waddr      = cnt;
    wdata      = {text_color, CH_SPACE};
    ren        = 1'b0;
    raddr      = lin(head.column, head.row);
    pop        = 1'b0;
    load       = 1'b0;
    go_scroll  = 1'b0;
    state_next = state;
    cnt_next   = cnt;
    cc_next    = cc;
    cl_next    = cl;
    res        = '0;
    case (state)
      S_INIT: begin
        wen   = 1'b1;
        wdata = {RESET_ATTR, CH_SPACE};
        if (cnt == CELL_W'(CELLS - 1)) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        if (!q_empty && out_free) begin
          pop = 1'b1;
          case (head.kind)
            CMD_PUT_CURSOR: begin
              if (head.character == CH_CR) begin
                cc_next = '0;
                load    = 1'b1;
              end else if (head.character == CH_LF) begin
                cc_next = '0;
                if (last_row) begin
                  go_scroll = 1'b1;
                end else begin
                  cl_next = cl + 1'b1;
                  load    = 1'b1;
                end
              end else begin
                wen   = 1'b1;
                waddr = lin(cc, cl);
                wdata = {text_color, head.character};
                if (cc == 7'(COLUMNS - 1)) begin
                  cc_next = '0;
                  if (last_row) begin
                    go_scroll = 1'b1;
                  end else begin
                    cl_next = cl + 1'b1;
                    load    = 1'b1;
                  end
                end else begin
                  cc_next = cc + 1'b1;
                  load    = 1'b1;
                end
              end
            end
            CMD_PUT_CELL: begin
              wen   = 1'b1;
              waddr = lin(head.column, head.row);
              wdata = {text_color, head.character};
              load  = 1'b1;
            end
            CMD_SET_CURSOR: begin
              cc_next = head.column;
              cl_next = head.row;
              load    = 1'b1;
            end
            CMD_CLEAR: begin
              cc_next    = '0;
              cl_next    = '0;
              cnt_next   = '0;
              state_next = S_CLEAR;
            end
            CMD_READ: begin
              ren        = 1'b1;
              state_next = S_READ;
            end
            default: begin
              load = 1'b1;
            end
          endcase
          if (go_scroll) begin
            cc_next    = '0;
            cl_next    = 5'(ROWS - 1);
            cnt_next   = '0;
            state_next = S_COPY;
          end
        end
      end
      S_READ: begin
        load               = 1'b1;
        res.cell_character = rdata[7:0];
        res.cell_color     = rdata[15:8];
        state_next         = S_IDLE;
      end
      S_COPY: begin
        // read one row ahead, write the word read in the cycle before
        if (cnt != CELL_W'(COPY_N)) begin
          ren      = 1'b1;
          raddr    = cnt + CELL_W'(COLUMNS);
          cnt_next = cnt + 1'b1;
        end else begin
          state_next = S_FILL;
        end
        if (cnt != '0) begin
          wen   = 1'b1;
          waddr = cnt - 1'b1;
          wdata = rdata;
        end
      end
      S_FILL: begin
        wen = 1'b1;
        if (cnt == CELL_W'(CELLS - 1)) begin
          load         = 1'b1;
          res.scrolled = 1'b1;
          cnt_next     = '0;
          state_next   = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_CLEAR: begin
        wen = 1'b1;
        if (cnt == CELL_W'(CELLS - 1)) begin
          load       = 1'b1;
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res.cursor_column = cc_next;
    res.cursor_row    = cl_next;
    res.cursor_linear = 11'(lin(cc_next, cl_next));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      cnt        <= '0;
      cc         <= '0;
      cl         <= '0;
      text_color <= RESET_ATTR;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      cc    <= cc_next;
      cl    <= cl_next;
      if (cfg_write) begin
        text_color <= cfg_data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/text_console_engine_unit.sv =====
// top level of the text console engine
// Character-cell text console with a ROWS x COLUMNS screen memory (one 16-bit cell per entry,
// attribute in the high byte, character in the low byte) and a cursor. Each input word is one
// operation and gives exactly one output word. After reset a clearing pass fills the screen with
// spaces in attribute 0x07, during which input words are stalled; text_color writes are taken at
// any time. A command queue, two entries deep by default, separates the input side from the
// executing side. From the queue, put-character without a scroll, put-at-cell, set-cursor and
// unused ops finish in the idle state; read-cell goes through a read state (registered memory
// read). A scroll runs over the single memory write port: a copy pass moves each row up, then
// a fill pass blanks the bottom row. Input is stalled while the queue is full.
module text_console_engine_unit import tce_pkg::*; #(
  parameter int COLUMNS     = DEF_COLUMNS,
  parameter int ROWS        = DEF_ROWS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  input  logic      cfg_write,
  input  logic [7:0] cfg_data
);

  back_status_t status;
  logic         push;
  cmd_t         push_cmd;
  logic         q_full;
  logic         q_empty;
  logic         pop;
  cmd_t         head;

  tce_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word (in_word),
    .q_full  (q_full),
    .status  (status),
    .push    (push),
    .cmd     (push_cmd)
  );

  tce_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty)
  );

  tce_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .status   (status),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

endmodule

// ===== sim/tb_text_console_engine_unit.sv =====
// self-checking testbench for the text console engine with queued driver and result monitor
module tb_text_console_engine_unit import tce_pkg::*; ();

  localparam int COLS = DEF_COLUMNS;
  localparam int LINES = DEF_ROWS;
  localparam int CELLS = COLS * LINES;
  localparam int CELL_W = $clog2(CELLS);
  localparam int IDLE_LIMIT = 50000;
  localparam int RANDOM_WORDS = 250;
  localparam int SETTLE_CYCLES = 20;

  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_write = 1'b0;
  logic [7:0] cfg_data = '0;

  // shadow of the screen, cursor and attribute
  logic [15:0] screen_model [CELLS];
  int cur_col;
  int cur_row;
  logic [7:0] attr_now;

  in_word_t pending_words[$];
  out_word_t expected_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int queued_words = 0;
  int taken_words = 0;
  int checked_words = 0;
  int mismatches = 0;
  int scroll_count = 0;
  int clear_count = 0;
  int read_count = 0;
  int color_settings = 1;
  int quiet_cycles = 0;

  text_console_engine_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [CELL_W-1:0] cell_at(input int col, input int row);
    return CELL_W'(row * COLS + col);
  endfunction

  function automatic out_word_t console_step(in_word_t w);
    out_word_t r;
    logic fits;
    int idx;
    r = '0;
    fits = (int'(w.column) < COLS) && (int'(w.row) < LINES);
    case (w.op)
      OP_PUT_CURSOR: begin
        if (w.character == CH_CR) begin
          cur_col = 0;
        end else if (w.character == CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else begin
          screen_model[cell_at(cur_col, cur_row)] = {attr_now, w.character};
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        if (cur_row >= LINES) begin
          for (idx = 0; idx < CELLS - COLS; idx++)
            screen_model[CELL_W'(idx)] = screen_model[CELL_W'(idx + COLS)];
          for (idx = CELLS - COLS; idx < CELLS; idx++)
            screen_model[CELL_W'(idx)] = {attr_now, CH_SPACE};
          cur_row = LINES - 1;
          cur_col = 0;
          r.scrolled = 1'b1;
        end
      end
      OP_PUT_CELL: begin
        if (fits)
          screen_model[cell_at(int'(w.column), int'(w.row))] = {attr_now, w.character};
      end
      OP_SET_CURSOR: begin
        if (fits) begin
          cur_col = int'(w.column);
          cur_row = int'(w.row);
        end
      end
      OP_CLEAR: begin
        for (idx = 0; idx < CELLS; idx++) screen_model[CELL_W'(idx)] = {attr_now, CH_SPACE};
        cur_col = 0;
        cur_row = 0;
      end
      OP_READ_CELL: begin
        if (fits)
          {r.cell_color, r.cell_character} = screen_model[cell_at(int'(w.column), int'(w.row))];
      end
      default: begin
      end
    endcase
    r.cursor_column = 7'(cur_col);
    r.cursor_row = 5'(cur_row);
    r.cursor_linear = 11'(cur_row * COLS + cur_col);
    return r;
  endfunction

  always @(posedge clk) begin : drive_words
    in_word_t nxt;
    out_word_t res;
    logic go;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        res = console_step(in_word);
        expected_results.push_back(res);
        taken_words++;
        if (res.scrolled) scroll_count++;
        if (in_word.op == OP_CLEAR) clear_count++;
        if (in_word.op == OP_READ_CELL) read_count++;
      end
      go = (pending_words.size() != 0) && ($urandom_range(99) >= send_idle_pct);
      if (go) begin
        nxt = pending_words.pop_front();
        in_word <= nxt;
      end
      in_valid <= go;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_words
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      checked_words++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_word);
      end else begin
        want = expected_results.pop_front();
        if (want.cursor_column !== out_word.cursor_column ||
            want.cursor_row !== out_word.cursor_row ||
            want.cursor_linear !== out_word.cursor_linear ||
            want.cell_character !== out_word.cell_character ||
            want.cell_color !== out_word.cell_color ||
            want.scrolled !== out_word.scrolled) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on word %0d: expected %p", checked_words, want);
            $display("                      actual   %p", out_word);
          end
        end
      end
    end
  end

  // idle watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a handshake", IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic queue_word(input logic [2:0] op, input logic [7:0] ch,
                            input logic [6:0] col, input logic [4:0] row);
    in_word_t w;
    w.op = op;
    w.character = ch;
    w.column = col;
    w.row = row;
    pending_words.push_back(w);
    queued_words++;
  endtask

  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return CH_CR;
    if (roll == 1) return CH_LF;
    return 8'($urandom);
  endfunction

  task automatic queue_burst();
    int kind;
    int c;
    int r;
    kind = $urandom_range(99);
    c = $urandom_range(COLS - 1);
    r = $urandom_range(LINES - 1);
    if (kind < 30) begin
      // run of text, often near the end of the last row
      if ($urandom_range(9) < 4) r = LINES - 1;
      if ($urandom_range(1) != 0) c = $urandom_range(COLS - 1, COLS - 8);
      queue_word(OP_SET_CURSOR, 8'($urandom), 7'(c), 5'(r));
      repeat ($urandom_range(8, 1))
        queue_word(OP_PUT_CURSOR, pick_char(), 7'($urandom), 5'($urandom));
    end else if (kind < 50) begin
      queue_word(OP_PUT_CELL, 8'($urandom), 7'(c), 5'(r));
      queue_word(OP_READ_CELL, 8'($urandom), 7'(c), 5'(r));
      if ($urandom_range(1) != 0) queue_word(OP_READ_CELL, 8'($urandom), 7'(c ^ 1), 5'(r));
    end else if (kind < 65) begin
      queue_word(OP_SET_CURSOR, 8'($urandom), 7'(c), 5'(r));
      queue_word(OP_PUT_CURSOR, pick_char(), 7'($urandom), 5'($urandom));
      queue_word(OP_READ_CELL, 8'($urandom), 7'(c), 5'(r));
    end else if (kind < 95) begin
      queue_word(3'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
    end else begin
      queue_word(OP_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
      queue_word(OP_READ_CELL, 8'($urandom), 7'(c), 5'(r));
    end
  endtask

  task automatic queue_random(input int count);
    int target;
    target = queued_words + count;
    while (queued_words < target) queue_burst();
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_color(input logic [7:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    attr_now = value;
    color_settings++;
  endtask

  initial begin : run_test
    int idx;
    for (idx = 0; idx < CELLS; idx++) screen_model[CELL_W'(idx)] = {RESET_ATTR, CH_SPACE};
    cur_col = 0;
    cur_row = 0;
    attr_now = RESET_ATTR;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 17;
    recv_idle_pct = 87;
    queue_word(OP_READ_CELL, 8'h00, 7'd0, 5'd0);
    queue_word(OP_READ_CELL, 8'hff, 7'(COLS - 1), 5'(LINES - 1));
    queue_word(OP_PUT_CELL, 8'hff, 7'(COLS - 1), 5'(LINES - 1));
    queue_word(OP_READ_CELL, 8'h00, 7'(COLS - 1), 5'(LINES - 1));
    queue_word(OP_PUT_CELL, 8'h41, 7'(COLS), 5'd0);
    queue_word(OP_READ_CELL, 8'h00, 7'(COLS), 5'd0);
    queue_word(OP_READ_CELL, 8'h00, 7'd0, 5'(LINES));
    queue_word(OP_SET_CURSOR, 8'h00, 7'h7f, 5'h1f);
    queue_word(OP_PUT_CELL, 8'h00, 7'd0, 5'd0);
    // wrap off the last row
    queue_word(OP_SET_CURSOR, 8'h00, 7'(COLS - 2), 5'(LINES - 1));
    queue_word(OP_PUT_CURSOR, 8'h41, 7'd0, 5'd0);
    queue_word(OP_PUT_CURSOR, 8'h42, 7'd0, 5'd0);
    queue_word(OP_READ_CELL, 8'h00, 7'(COLS - 2), 5'(LINES - 2));
    queue_word(OP_READ_CELL, 8'h00, 7'(COLS - 1), 5'(LINES - 1));
    // line feed on the last row
    queue_word(OP_SET_CURSOR, 8'h00, 7'd5, 5'(LINES - 1));
    queue_word(OP_PUT_CURSOR, CH_LF, 7'd0, 5'd0);
    queue_word(OP_SET_CURSOR, 8'h00, 7'd10, 5'd3);
    queue_word(OP_PUT_CURSOR, CH_CR, 7'd0, 5'd0);
    queue_word(OP_PUT_CURSOR, 8'h00, 7'd0, 5'd0);
    queue_word(OP_SPARE_5, 8'hff, 7'h7f, 5'h1f);
    queue_word(OP_SPARE_6, 8'h00, 7'd0, 5'd0);
    queue_word(OP_SPARE_7, 8'h5a, 7'd33, 5'd7);
    queue_word(OP_CLEAR, 8'h00, 7'd0, 5'd0);
    queue_word(OP_READ_CELL, 8'h00, 7'd0, 5'd0);
    queue_word(OP_READ_CELL, 8'h00, 7'(COLS - 1), 5'(LINES - 1));
    wait_idle();

    write_color(8'hff);
    queue_random(RANDOM_WORDS / 2);
    wait_idle();
    queue_random(RANDOM_WORDS - RANDOM_WORDS / 2);
    wait_idle();

    write_color(8'h00);
    send_idle_pct = 87;
    recv_idle_pct = 17;
    queue_random(RANDOM_WORDS);
    wait_idle();

    write_color(8'($urandom_range(254, 1)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(RANDOM_WORDS);
    wait_idle();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d ops: %0d scrolls, %0d clears, %0d cell reads, %0d attribute settings",
             taken_words, scroll_count, clear_count, read_count, color_settings);
    $display("checked %0d result words, %0d mismatches", checked_words, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
